>>> src/kte_pkg.sv
`default_nettype none
package kte_pkg;

    // command word, one per start
    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] key;
        logic [15:0] port;
        logic        host_given;
        logic [39:0] seen_at;
        logic        favorite;
        logic [39:0] now;
        logic [7:0]  index;
    } t_cmd_word;

    // result word, one per command
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  slot;
        logic [63:0] entry_key;
        logic [15:0] entry_port;
        logic [39:0] entry_last_seen;
        logic        entry_favorite;
        logic [8:0]  entry_count;
        logic [8:0]  favorite_total;
        logic [31:0] generation;
    } t_result_word;

    localparam logic [2:0] MODE_UPSERT = 3'd0;
    localparam logic [2:0] MODE_SETFAV = 3'd1;
    localparam logic [2:0] MODE_SWEEP  = 3'd2;
    localparam logic [2:0] MODE_FIND   = 3'd3;
    localparam logic [2:0] MODE_NTH    = 3'd4;
    localparam logic [2:0] MODE_READ   = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_NOSPACE  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_SKIPPED  = 3'd4;

    localparam logic       REG_CLOCK_VALID = 1'b0;
    localparam logic       REG_STALE_AGE   = 1'b1;

    localparam logic [39:0] CLOCK_VALID_RESET = 40'd1700000000;
    localparam logic [31:0] STALE_AGE_RESET   = 32'd604800;

endpackage
`default_nettype wire

>>> src/keyed_table_stalest_evict.sv
`default_nettype none
// Keyed record table with stalest-record eviction.
// Command channel: present i_cmd with start; the word is taken at an edge
// with start high and busy low. busy stays high until the result is issued.
// Result channel: o_done pulses for one cycle with o_result; the receiver
// must take it then, it cannot stall the block.
// Records sit in one single-port-write, one-read memory with a registered read.
// Rejected commands, skipped sweeps and out-of-range slot reads give their
// result in the cycle after accept; a slot read goes through S_SLOT first.
// Upsert, set favourite, find, nth favourite and sweep walk the table one
// record per cycle through the memory read port, stopping early when a key
// or favourite is found. One command at a time; the next may be accepted
// the cycle o_done is high.
// Sweep compacts in place: write pointer never passes the read pointer.
// Reset: table empty, generation 1, registers at their defaults; memory
// contents are left as they are (only entries below the count are read).
// APB: clock_valid_after at 0x0, stale_age at 0x8, 64-bit data, no waits.
module keyed_table_stalest_evict
    import kte_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int KEY_BITS  = 64,
    parameter int TIME_BITS = 40
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire t_cmd_word    i_cmd,
    output logic              o_done,
    output t_result_word      o_result,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic      [63:0]  prdata,
    output logic              pready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [15:0]          port;
        logic [TIME_BITS-1:0] seen;
        logic                 fav;
    } t_rec;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_SLOT} t_state;

    t_state               r_state, n_state;
    logic [2:0]           r_mode, n_mode;
    logic [KEY_BITS-1:0]  r_key, n_key;
    logic [15:0]          r_port, n_port;
    logic [TIME_BITS-1:0] r_seen, n_seen;
    logic                 r_fav, n_fav;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [7:0]           r_left, n_left;
    logic [CW-1:0]        r_rd_idx, n_rd_idx;
    logic                 r_dv, n_dv;
    logic [AW-1:0]        r_dv_idx, n_dv_idx;
    logic                 r_hit, n_hit;
    logic [AW-1:0]        r_hit_idx, n_hit_idx;
    t_rec                 r_hit_rec, n_hit_rec;
    logic                 r_min_ok, n_min_ok;
    logic [AW-1:0]        r_min_idx, n_min_idx;
    logic [TIME_BITS-1:0] r_min_seen, n_min_seen;
    logic [CW-1:0]        r_kept, n_kept;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_favs, n_favs;
    logic [31:0]          r_gen, n_gen;
    logic                 r_done, n_done;
    t_result_word         r_res, n_res;
    logic [39:0]          r_cva;
    logic [31:0]          r_stale;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    t_rec                 mem_wdata;
    logic [AW-1:0]        mem_raddr;
    t_rec                 rd_rec;

    kte_ram #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_rec)
    );

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_STALE_AGE) ? {32'd0, r_stale} : {24'd0, r_cva};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cva   <= CLOCK_VALID_RESET;
            r_stale <= STALE_AGE_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[3] == REG_STALE_AGE) begin
                r_stale <= pwdata[31:0];
            end else begin
                r_cva <= pwdata[39:0];
            end
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    always_comb begin
        logic [63:0]          k64, s64, t64, cva64, age64, diff64, key64, seen64;
        logic [KEY_BITS-1:0]  key_in;
        logic [TIME_BITS-1:0] diff;
        logic [31:0]          idx32, slot32, cnt32, fav32;
        logic                 fin, show, hit_now, stale, old_fav, new_fav;
        logic [2:0]           status;
        logic [AW-1:0]        slot;
        t_rec                 rec;

        n_state    = r_state;
        n_mode     = r_mode;
        n_key      = r_key;
        n_port     = r_port;
        n_seen     = r_seen;
        n_fav      = r_fav;
        n_now      = r_now;
        n_left     = r_left;
        n_rd_idx   = r_rd_idx;
        n_dv       = r_dv;
        n_dv_idx   = r_dv_idx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_rec  = r_hit_rec;
        n_min_ok   = r_min_ok;
        n_min_idx  = r_min_idx;
        n_min_seen = r_min_seen;
        n_kept     = r_kept;
        n_count    = r_count;
        n_favs     = r_favs;
        n_gen      = r_gen;
        n_done     = 1'b0;
        n_res      = r_res;

        mem_we    = 1'b0;
        mem_waddr = r_kept[AW-1:0];
        mem_wdata = rd_rec;
        mem_raddr = r_rd_idx[AW-1:0];

        k64     = i_cmd.key;
        key_in  = k64[KEY_BITS-1:0];
        s64     = 64'(i_cmd.seen_at);
        t64     = 64'(i_cmd.now);
        cva64   = 64'(r_cva);
        age64   = 64'(r_stale);
        idx32   = 32'(i_cmd.index);
        diff    = r_now - rd_rec.seen;
        diff64  = 64'(diff);
        stale   = !rd_rec.fav && (rd_rec.seen < r_now) && (diff64 > age64);
        fin     = 1'b0;
        show    = 1'b0;
        hit_now = 1'b0;
        status  = ST_OK;
        slot    = '0;
        rec     = rd_rec;
        old_fav = 1'b0;
        new_fav = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mode   = i_cmd.mode;
                    n_key    = key_in;
                    n_port   = i_cmd.port;
                    n_seen   = s64[TIME_BITS-1:0];
                    n_fav    = i_cmd.favorite;
                    n_now    = t64[TIME_BITS-1:0];
                    n_left   = i_cmd.index;
                    n_rd_idx = '0;
                    n_dv     = 1'b0;
                    n_hit    = 1'b0;
                    n_min_ok = 1'b0;
                    n_kept   = '0;
                    priority if (i_cmd.mode == MODE_UPSERT) begin
                        if (key_in == '0 || i_cmd.port == 16'd0 || !i_cmd.host_given) begin
                            fin    = 1'b1;
                            status = ST_INVALID;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (i_cmd.mode == MODE_SETFAV || i_cmd.mode == MODE_FIND) begin
                        if (key_in == '0) begin
                            fin    = 1'b1;
                            status = ST_INVALID;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (i_cmd.mode == MODE_SWEEP) begin
                        if ((64'(t64[TIME_BITS-1:0])) < cva64) begin
                            fin    = 1'b1;
                            status = ST_SKIPPED;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (i_cmd.mode == MODE_NTH) begin
                        n_state = S_SCAN;
                    end else if (i_cmd.mode == MODE_READ) begin
                        if (idx32 < 32'(r_count)) begin
                            mem_raddr = idx32[AW-1:0];
                            n_hit_idx = idx32[AW-1:0];
                            n_state   = S_SLOT;
                        end else begin
                            fin    = 1'b1;
                            status = ST_NOTFOUND;
                        end
                    end else begin
                        fin    = 1'b1;
                        status = ST_INVALID;
                    end
                end
            end

            S_SCAN: begin
                if (r_dv) begin
                    priority if (r_mode == MODE_UPSERT) begin
                        if (rd_rec.key == r_key) begin
                            hit_now = 1'b1;
                        end else if (!rd_rec.fav && (!r_min_ok || rd_rec.seen < r_min_seen)) begin
                            n_min_ok   = 1'b1;
                            n_min_idx  = r_dv_idx;
                            n_min_seen = rd_rec.seen;
                        end
                    end else if (r_mode == MODE_SETFAV || r_mode == MODE_FIND) begin
                        hit_now = (rd_rec.key == r_key);
                    end else if (r_mode == MODE_NTH) begin
                        if (rd_rec.fav) begin
                            if (r_left == 8'd0) begin
                                hit_now = 1'b1;
                            end else begin
                                n_left = r_left - 8'd1;
                            end
                        end
                    end else begin
                        // sweep: keep survivors, packed down in order
                        if (!stale) begin
                            mem_we = 1'b1;
                            n_kept = r_kept + CW'(1);
                        end
                    end
                end
                if (hit_now) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_dv_idx;
                    n_hit_rec = rd_rec;
                    n_dv      = 1'b0;
                    n_state   = S_COMMIT;
                end else if (r_rd_idx < r_count) begin
                    n_dv     = 1'b1;
                    n_dv_idx = r_rd_idx[AW-1:0];
                    n_rd_idx = r_rd_idx + CW'(1);
                end else begin
                    n_dv = 1'b0;
                    if (!r_dv) begin
                        n_state = S_COMMIT;
                    end
                end
            end

            S_COMMIT: begin
                n_state = S_IDLE;
                fin     = 1'b1;
                priority if (r_mode == MODE_UPSERT) begin
                    show = 1'b1;
                    if (r_hit) begin
                        slot    = r_hit_idx;
                        old_fav = r_hit_rec.fav;
                    end else if (r_count < CW'(DEPTH)) begin
                        slot    = r_count[AW-1:0];
                        n_count = r_count + CW'(1);
                    end else if (r_min_ok) begin
                        slot = r_min_idx;
                    end else begin
                        show   = 1'b0;
                        status = ST_NOSPACE;
                    end
                    if (show) begin
                        new_fav   = old_fav | r_fav;
                        rec       = '{key: r_key, port: r_port, seen: r_seen, fav: new_fav};
                        mem_we    = 1'b1;
                        mem_waddr = slot;
                        mem_wdata = rec;
                        n_gen     = r_gen + 32'd1;
                        n_favs    = r_favs + CW'(new_fav) - CW'(old_fav);
                    end
                end else if (r_mode == MODE_SETFAV) begin
                    if (r_hit) begin
                        show      = 1'b1;
                        slot      = r_hit_idx;
                        rec       = r_hit_rec;
                        rec.fav   = r_fav;
                        mem_we    = 1'b1;
                        mem_waddr = slot;
                        mem_wdata = rec;
                        n_gen     = r_gen + 32'd1;
                        n_favs    = r_favs + CW'(r_fav) - CW'(r_hit_rec.fav);
                    end else begin
                        status = ST_NOTFOUND;
                    end
                end else if (r_mode == MODE_FIND || r_mode == MODE_NTH) begin
                    if (r_hit) begin
                        show = 1'b1;
                        slot = r_hit_idx;
                        rec  = r_hit_rec;
                    end else begin
                        status = ST_NOTFOUND;
                    end
                end else begin
                    // sweep only drops non-favourites, so the favourite count holds
                    if (r_kept != r_count) begin
                        n_count = r_kept;
                        n_gen   = r_gen + 32'd1;
                    end
                end
            end

            S_SLOT: begin
                n_state = S_IDLE;
                fin     = 1'b1;
                show    = 1'b1;
                slot    = r_hit_idx;
                rec     = rd_rec;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_done = 1'b1;
            slot32 = 32'(slot);
            cnt32  = 32'(n_count);
            fav32  = 32'(n_favs);
            key64  = 64'(rec.key);
            seen64 = 64'(rec.seen);
            n_res.status         = status;
            n_res.entry_count    = cnt32[8:0];
            n_res.favorite_total = fav32[8:0];
            n_res.generation     = n_gen;
            if (show && status == ST_OK) begin
                n_res.slot            = slot32[7:0];
                n_res.entry_key       = key64;
                n_res.entry_port      = rec.port;
                n_res.entry_last_seen = seen64[39:0];
                n_res.entry_favorite  = rec.fav;
            end else begin
                n_res.slot            = '0;
                n_res.entry_key       = '0;
                n_res.entry_port      = '0;
                n_res.entry_last_seen = '0;
                n_res.entry_favorite  = 1'b0;
            end
        end else begin
            slot32 = '0;
            cnt32  = '0;
            fav32  = '0;
            key64  = '0;
            seen64 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dv    <= 1'b0;
            r_count <= '0;
            r_favs  <= '0;
            r_gen   <= 32'd1;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= n_dv;
            r_count <= n_count;
            r_favs  <= n_favs;
            r_gen   <= n_gen;
            r_done  <= n_done;
        end
        r_mode     <= n_mode;
        r_key      <= n_key;
        r_port     <= n_port;
        r_seen     <= n_seen;
        r_fav      <= n_fav;
        r_now      <= n_now;
        r_left     <= n_left;
        r_rd_idx   <= n_rd_idx;
        r_dv_idx   <= n_dv_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_rec  <= n_hit_rec;
        r_min_ok   <= n_min_ok;
        r_min_idx  <= n_min_idx;
        r_min_seen <= n_min_seen;
        r_kept     <= n_kept;
        r_res      <= n_res;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("record count above depth");

    a_favs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_favs <= r_count)
        else $error("favourite total above record count");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_SCAN || r_state == S_COMMIT))
        else $error("table written while idle");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_kept <= r_rd_idx))
        else $error("compaction write pointer passed read pointer");

endmodule
`default_nettype wire

>>> src/kte_ram.sv
`default_nettype none
module kte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> dv/kte_checker.sv
`default_nettype none
module kte_checker
    import kte_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    input  wire logic         busy,
    input  wire t_cmd_word    i_cmd,
    input  wire logic         o_done,
    input  wire t_result_word o_result,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic         pready,
    input  wire logic [3:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output int                fail_count,
    output int                pending,
    output int                words_checked,
    output int                evictions
);
    localparam int SLOTS = 256;

    logic [63:0] rec_key  [SLOTS];
    logic [15:0] rec_port [SLOTS];
    logic [39:0] rec_seen [SLOTS];
    logic        rec_fav  [SLOTS];
    int          rec_count;
    logic [31:0] gen_count;
    logic [39:0] clock_valid;
    logic [31:0] stale_limit;

    t_result_word expected_words[$];

    task automatic report(input string field, input logic [63:0] got,
                          input logic [63:0] want);
        $display("%0t: %s got %0h want %0h", $realtime, field, got, want);
        fail_count++;
    endtask

    function automatic int find_slot(input logic [63:0] k);
        for (int i = 0; i < rec_count; i++)
            if (rec_key[i] == k) return i;
        return SLOTS;
    endfunction

    // Apply one command to the shadow table and return the word it yields
    function automatic t_result_word apply_cmd(input t_cmd_word c);
        t_result_word r;
        int           at;
        int           kept;
        int           left;
        int           favs;
        logic [2:0]   st;
        logic         stale;
        st = ST_OK;
        at = SLOTS;
        r  = '0;
        case (c.mode)
            MODE_UPSERT: begin
                if (c.key == 0 || c.port == 0 || !c.host_given) begin
                    st = ST_INVALID;
                end else begin
                    logic old_fav;
                    old_fav = 1'b0;
                    at = find_slot(c.key);
                    if (at < SLOTS) begin
                        old_fav = rec_fav[at];
                    end else if (rec_count >= SLOTS) begin
                        for (int i = 0; i < rec_count; i++) begin
                            if (rec_fav[i]) continue;
                            if (at >= SLOTS || rec_seen[i] < rec_seen[at]) at = i;
                        end
                        if (at < SLOTS) evictions++;
                    end else begin
                        at = rec_count;
                        rec_count++;
                    end
                    if (at >= SLOTS) begin
                        st = ST_NOSPACE;
                    end else begin
                        rec_key[at]  = c.key;
                        rec_port[at] = c.port;
                        rec_seen[at] = c.seen_at;
                        rec_fav[at]  = old_fav | c.favorite;
                        gen_count++;
                    end
                end
            end
            MODE_SETFAV: begin
                if (c.key == 0) begin
                    st = ST_INVALID;
                end else begin
                    at = find_slot(c.key);
                    if (at >= SLOTS) begin
                        st = ST_NOTFOUND;
                    end else begin
                        rec_fav[at] = c.favorite;
                        gen_count++;
                    end
                end
            end
            MODE_SWEEP: begin
                if (c.now < clock_valid) begin
                    st = ST_SKIPPED;
                end else begin
                    kept = 0;
                    for (int i = 0; i < rec_count; i++) begin
                        stale = !rec_fav[i] && rec_seen[i] < c.now &&
                                (c.now - rec_seen[i]) > {8'd0, stale_limit};
                        if (stale) continue;
                        rec_key[kept]  = rec_key[i];
                        rec_port[kept] = rec_port[i];
                        rec_seen[kept] = rec_seen[i];
                        rec_fav[kept]  = rec_fav[i];
                        kept++;
                    end
                    if (kept != rec_count) begin
                        rec_count = kept;
                        gen_count++;
                    end
                end
            end
            MODE_FIND: begin
                if (c.key == 0) begin
                    st = ST_INVALID;
                end else begin
                    at = find_slot(c.key);
                    if (at >= SLOTS) st = ST_NOTFOUND;
                end
            end
            MODE_NTH: begin
                left = c.index;
                for (int i = 0; i < rec_count; i++) begin
                    if (!rec_fav[i]) continue;
                    if (left == 0) begin
                        at = i;
                        break;
                    end
                    left--;
                end
                if (at >= SLOTS) st = ST_NOTFOUND;
            end
            MODE_READ: begin
                if (c.index < rec_count) at = c.index;
                else st = ST_NOTFOUND;
            end
            default: st = ST_INVALID;
        endcase
        r.status = st;
        if (st == ST_OK && at < SLOTS && c.mode != MODE_SWEEP) begin
            r.slot            = at[7:0];
            r.entry_key       = rec_key[at];
            r.entry_port      = rec_port[at];
            r.entry_last_seen = rec_seen[at];
            r.entry_favorite  = rec_fav[at];
        end
        favs = 0;
        for (int i = 0; i < rec_count; i++) favs += rec_fav[i];
        r.entry_count    = rec_count[8:0];
        r.favorite_total = favs[8:0];
        r.generation     = gen_count;
        return r;
    endfunction

    task automatic compare_word(input t_result_word got, input t_result_word want);
        if (got.status != want.status)           report("status", got.status, want.status);
        if (got.slot != want.slot)               report("slot", got.slot, want.slot);
        if (got.entry_key != want.entry_key)     report("entry_key", got.entry_key,
                                                        want.entry_key);
        if (got.entry_port != want.entry_port)   report("entry_port", got.entry_port,
                                                        want.entry_port);
        if (got.entry_last_seen != want.entry_last_seen)
            report("entry_last_seen", got.entry_last_seen, want.entry_last_seen);
        if (got.entry_favorite != want.entry_favorite)
            report("entry_favorite", got.entry_favorite, want.entry_favorite);
        if (got.entry_count != want.entry_count)
            report("entry_count", got.entry_count, want.entry_count);
        if (got.favorite_total != want.favorite_total)
            report("favorite_total", got.favorite_total, want.favorite_total);
        if (got.generation != want.generation)
            report("generation", got.generation, want.generation);
    endtask

    initial begin
        fail_count    = 0;
        words_checked = 0;
        evictions     = 0;
        rec_count     = 0;
        gen_count     = 32'd1;
        clock_valid   = CLOCK_VALID_RESET;
        stale_limit   = STALE_AGE_RESET;
    end

    assign pending = expected_words.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rec_count   = 0;
            gen_count   = 32'd1;
            clock_valid = CLOCK_VALID_RESET;
            stale_limit = STALE_AGE_RESET;
            expected_words.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == {REG_CLOCK_VALID, 3'b000}) clock_valid = pwdata[39:0];
                else if (paddr == {REG_STALE_AGE, 3'b000}) stale_limit = pwdata[31:0];
            end
            if (o_done) begin
                if (expected_words.size() == 0) begin
                    report("unexpected word, status", o_result.status, 0);
                end else begin
                    compare_word(o_result, expected_words.pop_front());
                    words_checked++;
                end
            end
            if (start && !busy) expected_words.push_back(apply_cmd(i_cmd));
        end
    end
endmodule
`default_nettype wire

>>> dv/keyed_table_stalest_evict_tb.sv
`default_nettype none
module keyed_table_stalest_evict_tb;
    import kte_pkg::*;

    localparam logic [39:0] EPOCH = 40'd1700000000;   // start of the usual time window
    localparam logic [2:0]  MODE_SPARE_LO = 3'd6;     // unused mode codes
    localparam logic [2:0]  MODE_SPARE_HI = 3'd7;

    logic         i_clk   = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         start   = 1'b0;
    logic         busy;
    t_cmd_word    cmd_word = '0;
    logic         o_done;
    t_result_word o_result;
    logic         psel    = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite  = 1'b0;
    logic [3:0]   paddr   = '0;
    logic [63:0]  pwdata  = '0;
    logic [63:0]  prdata;
    logic         pready;

    int fail_count, pending, words_checked, evictions;
    int words_sent = 0;
    int settings_used = 0;

    logic [63:0] known_keys[$];    // keys already offered, for hits on live records

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    keyed_table_stalest_evict dut (
        .i_clk, .i_rst_n, .start, .busy, .i_cmd(cmd_word), .o_done, .o_result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    // checker sits beside the block, predicting and comparing every word
    kte_checker u_check (
        .i_clk, .i_rst_n, .start, .busy, .i_cmd(cmd_word), .o_done, .o_result,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .fail_count, .pending, .words_checked, .evictions
    );

    // watchdog: far beyond a full-table walk per word plus the longest gaps
    initial begin
        #8000000;
        $display("Mismatches found");
        $finish;
    end

    // Offer one word from a falling edge, hold until taken, then at times idle a while
    task automatic issue(input t_cmd_word c);
        int r;
        start    = 1'b1;
        cmd_word = c;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start = 1'b0;
        words_sent++;
        r = $urandom_range(0, 99);
        if (r >= 90)      repeat ($urandom_range(10, 60)) @(negedge i_clk);
        else if (r >= 60) repeat ($urandom_range(1, 3)) @(negedge i_clk);
    endtask

    // Register write only once the table has gone quiet
    task automatic write_reg(input logic idx, input logic [63:0] value);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_regs(input logic [39:0] valid_after, input logic [31:0] age);
        write_reg(REG_CLOCK_VALID, {24'd0, valid_after});
        write_reg(REG_STALE_AGE, {32'd0, age});
        settings_used++;
    endtask

    // Mostly near the epoch so stale ages bite; now and then any 40-bit value
    function automatic logic [39:0] pick_time();
        if ($urandom_range(0, 7) == 0) return {8'($urandom_range(0, 255)), $urandom};
        return EPOCH + $urandom_range(0, 2000000);
    endfunction

    function automatic logic [63:0] pick_key(input bit fresh);
        logic [63:0] k;
        if (!fresh && known_keys.size() > 0)
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        k = {$urandom, $urandom};
        if (k == 0) k = 64'd1;
        if (known_keys.size() < 700) known_keys.push_back(k);
        return k;
    endfunction

    function automatic t_cmd_word plain(input logic [2:0] mode);
        t_cmd_word c;
        c            = '0;
        c.mode       = mode;
        c.host_given = 1'b1;
        return c;
    endfunction

    task automatic random_word();
        t_cmd_word    c;
        int           r;
        logic [191:0] noise;
        c            = '0;
        c.key        = pick_key($urandom_range(0, 99) < 70);
        c.port       = 16'($urandom_range(1, 65535));
        c.host_given = 1'b1;
        c.seen_at    = pick_time();
        c.favorite   = ($urandom_range(0, 99) < 12);
        c.now        = pick_time() + $urandom_range(0, 1500000);
        c.index      = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 46) begin
            c.mode = MODE_UPSERT;
        end else if (r < 54) begin
            c.mode     = MODE_SETFAV;
            c.key      = pick_key(0);
            c.favorite = 1'($urandom_range(0, 1));
        end else if (r < 61) begin
            c.mode = MODE_SWEEP;
        end else if (r < 72) begin
            c.mode = MODE_FIND;
            c.key  = pick_key($urandom_range(0, 3) == 0);
        end else if (r < 79) begin
            c.mode  = MODE_NTH;
            if ($urandom_range(0, 1)) c.index = 8'($urandom_range(0, 15));
        end else if (r < 93) begin
            c.mode = MODE_READ;
        end else begin
            // malformed: bad mode, zero key or port, missing host, all random
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            c = noise[$bits(t_cmd_word)-1:0];
            case ($urandom_range(0, 3))
                0: c.key = '0;
                1: c.port = '0;
                2: c.host_given = 1'b0;
                default: ;
            endcase
        end
        issue(c);
    endtask

    task automatic directed_words();
        t_cmd_word c;
        issue(plain(MODE_READ));                     // empty table, slot 0
        c = plain(MODE_FIND);        issue(c);       // key zero
        c = plain(MODE_SETFAV);      issue(c);
        c = plain(MODE_NTH);         issue(c);       // no favourites yet
        c = plain(MODE_UPSERT); c.port = 16'd5;      issue(c);   // key zero
        c = plain(MODE_UPSERT); c.key = 64'd7;       issue(c);   // port zero
        c = plain(MODE_UPSERT); c.key = 64'd7; c.port = 16'd5; c.host_given = 1'b0;
        issue(c);
        issue(plain(MODE_SPARE_LO));
        c = plain(MODE_SPARE_HI); c = ~c; c.mode = MODE_SPARE_HI; issue(c);
        // widest values
        c = plain(MODE_UPSERT);
        c.key = '1; c.port = '1; c.seen_at = '1; c.favorite = 1'b1;
        issue(c);
        c.favorite = 1'b0; c.port = 16'h8001;        issue(c);   // OR keeps the mark
        c = plain(MODE_UPSERT); c.key = 64'd1; c.port = 16'd1; issue(c);
        c = plain(MODE_UPSERT); c.key = 64'd2; c.port = 16'd2;
        c.seen_at = EPOCH + 40'd5000000;                         // seen in the future
        issue(c);
        c = plain(MODE_SETFAV); c.key = 64'd99;      issue(c);   // unknown key
        c = plain(MODE_SETFAV); c.key = '1;          issue(c);   // clear the mark
        c = plain(MODE_FIND); c.key = 64'd2;         issue(c);
        c = plain(MODE_SWEEP); c.now = EPOCH - 40'd1; issue(c);  // clock not synced
        c = plain(MODE_SWEEP); c.now = EPOCH;        issue(c);
        c = plain(MODE_SWEEP); c.now = '1;           issue(c);
        c = plain(MODE_SWEEP); c.now = '1;           issue(c);   // nothing left to drop
        c = plain(MODE_NTH); c.index = 8'd255;       issue(c);
        c = plain(MODE_READ); c.index = 8'd255;      issue(c);
        c = plain(MODE_READ); c.index = 8'd0;        issue(c);
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        directed_words();
        settings_used = 1;
        // defaults from reset first, then the extremes and a couple of mid points
        repeat (380) random_word();
        set_regs('0, '0);
        repeat (380) random_word();
        set_regs('1, '1);                    // sweeps skip unless now is maximal
        repeat (380) random_word();
        set_regs(EPOCH, 32'd100000);
        repeat (380) random_word();
        set_regs(EPOCH + $urandom_range(0, 1000000), $urandom);
        repeat (380) random_word();
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        $display("Sent %0d command words under %0d register settings; %0d result words",
                 words_sent, settings_used, words_checked);
        $display("Stalest-record evictions seen on a full table: %0d", evictions);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
